// ----- design/salsc_pkg.sv -----
// ----------------------------------------------------------------------------
// salsc_pkg
// Shared types and codes for the sprite attribute line scan core.
// ----------------------------------------------------------------------------
package salsc_pkg;

    localparam logic [1:0] CMD_WRITE = 2'd0;
    localparam logic [1:0] CMD_READ  = 2'd1;
    localparam logic [1:0] CMD_SCAN  = 2'd2;
    localparam logic [1:0] CMD_NONE  = 2'd3;

    localparam logic [8:0] LINE_OFFSET = 9'd16;
    localparam logic [8:0] HEIGHT_SHORT = 9'd8;
    localparam logic [8:0] HEIGHT_TALL  = 9'd16;

    typedef struct packed {
        logic [1:0] cmd;
        logic [7:0] address;
        logic [7:0] write_data;
        logic [7:0] line_y;
        logic       tall_sprites;
    } t_in_word;

    typedef struct packed {
        logic       status;
        logic [7:0] read_data;
        logic [3:0] sel_count;
        logic [7:0] sprite_y;
        logic [7:0] sprite_x;
        logic [7:0] sprite_tile;
        logic [7:0] sprite_flags;
        logic [5:0] sprite_slot;
        logic       last;
    } t_out_word;

    typedef struct packed {
        logic [1:0] kind;
        logic       oob;
        logic [5:0] entry;
        logic [1:0] lane;
        logic [7:0] wdata;
        logic [8:0] target;
        logic [8:0] height;
    } t_cmd_word;

    typedef struct packed {
        logic [5:0] slot;
        logic [7:0] y;
        logic [7:0] x;
        logic [7:0] tile;
        logic [7:0] flags;
    } t_pick;

endpackage

// ----- design/salsc_ram.sv -----
// ----------------------------------------------------------------------------
// salsc_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module salsc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 40
) (
    input  logic                                     i_clk,
    input  logic                                     i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                         i_wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ----- design/salsc_front.sv -----
// ----------------------------------------------------------------------------
// salsc_front
// Accepts commands, classifies them and holds them in a two-deep queue.
// ----------------------------------------------------------------------------
module salsc_front #(
    parameter int NUM_ENTRIES = 40
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  salsc_pkg::t_in_word  i_item,
    output logic                 o_full,
    output logic                 o_valid,
    output salsc_pkg::t_cmd_word o_cmd,
    input  logic                 i_take
);
    import salsc_pkg::*;

    localparam logic [8:0] MEM_BYTES = 9'(NUM_ENTRIES * 4);

    t_cmd_word  r_q [2];
    logic       r_rd, n_rd;
    logic       r_wr, n_wr;
    logic [1:0] r_cnt, n_cnt;
    t_cmd_word  w_cls;
    logic       w_push, w_take;

    always_comb begin
        w_cls.kind   = i_item.cmd;
        w_cls.oob    = {1'b0, i_item.address} >= MEM_BYTES;
        w_cls.entry  = i_item.address[7:2];
        w_cls.lane   = i_item.address[1:0];
        w_cls.wdata  = i_item.write_data;
        w_cls.target = {1'b0, i_item.line_y} + LINE_OFFSET;
        w_cls.height = i_item.tall_sprites ? HEIGHT_TALL : HEIGHT_SHORT;
    end

    assign w_push = i_push && !o_full;
    assign w_take = i_take && o_valid;
    assign n_wr   = w_push ? ~r_wr : r_wr;
    assign n_rd   = w_take ? ~r_rd : r_rd;
    assign n_cnt  = r_cnt + {1'b0, w_push} - {1'b0, w_take};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd  <= 1'b0;
            r_wr  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            r_rd  <= n_rd;
            r_wr  <= n_wr;
            r_cnt <= n_cnt;
        end
        if (w_push) begin
            r_q[r_wr] <= w_cls;
        end
    end

    assign o_full  = r_cnt == 2'd2;
    assign o_valid = r_cnt != 2'd0;
    assign o_cmd   = r_q[r_rd];
endmodule

// ----- design/salsc_back.sv -----
// ----------------------------------------------------------------------------
// salsc_back
// Executes byte writes, byte reads and line scans against the attribute
// memory, keeps the sorted pick list and drives the result register.
// ----------------------------------------------------------------------------
module salsc_back #(
    parameter int NUM_ENTRIES  = 40,
    parameter int MAX_PER_LINE = 10
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    input  salsc_pkg::t_cmd_word i_cmd,
    output logic                 o_take,
    output logic                 o_empty,
    output salsc_pkg::t_out_word o_result,
    input  logic                 i_pop
);
    import salsc_pkg::*;

    localparam int EW = NUM_ENTRIES > 1 ? $clog2(NUM_ENTRIES) : 1;
    localparam int IW = $clog2(NUM_ENTRIES + 1);
    localparam int CW = $clog2(MAX_PER_LINE + 1);
    localparam int KW = MAX_PER_LINE > 1 ? $clog2(MAX_PER_LINE) : 1;
    localparam int NB = NUM_ENTRIES * 4;
    localparam logic [IW-1:0] LAST_IDX = IW'(NUM_ENTRIES);
    localparam logic [CW-1:0] CNT_MAX  = CW'(MAX_PER_LINE);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_READ = 2'd1;
    localparam logic [1:0] ST_SCAN = 2'd2;
    localparam logic [1:0] ST_EMIT = 2'd3;

    logic [1:0]    r_st, n_st;
    logic [NB-1:0] r_vld;
    logic [IW-1:0] r_idx, n_idx;
    logic          r_pend, n_pend;
    logic [5:0]    r_pslot;
    logic [3:0]    r_pvld;
    logic [1:0]    r_lane;
    logic [EW-1:0] r_rentry;
    logic [8:0]    r_target, r_height;
    logic [CW-1:0] r_cnt, n_cnt;
    logic [KW-1:0] r_k, n_k;
    t_pick         r_list [MAX_PER_LINE];
    t_pick         n_list [MAX_PER_LINE];
    logic          r_ov, n_ov;
    t_out_word     r_out, n_out;

    logic          w_emit_ok;
    logic [3:0]    w_we;
    logic [EW-1:0] w_raddr;
    logic [7:0]    w_rd [4];
    logic [7:0]    w_byte [4];
    logic          w_issue, w_hit, w_ins;
    t_pick         w_p;
    logic [MAX_PER_LINE-1:0] w_gt;
    logic [CW+3:0] w_cnt_ext;
    logic [KW:0]   w_knext;

    genvar g;
    generate
        for (g = 0; g < 4; g++) begin : g_lane
            salsc_ram #(.WIDTH(8), .DEPTH(NUM_ENTRIES)) u_ram (
                .i_clk   (i_clk),
                .i_we    (w_we[g]),
                .i_waddr (i_cmd.entry[EW-1:0]),
                .i_wdata (i_cmd.wdata),
                .i_raddr (w_raddr),
                .o_rdata (w_rd[g])
            );
            assign w_byte[g] = r_pvld[g] ? w_rd[g] : 8'd0;
        end
    endgenerate

    assign w_emit_ok = !r_ov || i_pop;
    assign w_issue   = (r_st == ST_SCAN) && (r_idx != LAST_IDX) && (r_cnt != CNT_MAX);
    assign w_raddr   = (r_st == ST_SCAN) ? r_idx[EW-1:0] :
                       (r_st == ST_READ) ? r_rentry : i_cmd.entry[EW-1:0];

    always_comb begin
        w_we = 4'd0;
        if (r_st == ST_IDLE && i_valid && i_cmd.kind == CMD_WRITE && !i_cmd.oob
            && w_emit_ok) begin
            w_we[i_cmd.lane] = 1'b1;
        end
    end

    assign w_p.slot  = r_pslot;
    assign w_p.y     = w_byte[0];
    assign w_p.x     = w_byte[1];
    assign w_p.tile  = w_byte[2];
    assign w_p.flags = w_byte[3];
    assign w_hit = ({1'b0, w_p.y} <= r_target) && ({1'b0, w_p.y} + r_height > r_target)
                   && (w_p.x != 8'd0);
    assign w_ins = r_pend && w_hit && (r_cnt != CNT_MAX);

    always_comb begin
        for (int j = 0; j < MAX_PER_LINE; j++) begin
            w_gt[j] = (CW'(j) < r_cnt) && (r_list[j].x > w_p.x);
        end
        for (int j = 0; j < MAX_PER_LINE; j++) begin
            if (j > 0 && w_gt[(j > 0) ? j - 1 : 0]) begin
                n_list[j] = r_list[(j > 0) ? j - 1 : 0];
            end else if (w_ins && (w_gt[j] || CW'(j) == r_cnt)) begin
                n_list[j] = w_p;
            end else begin
                n_list[j] = r_list[j];
            end
            if (!w_ins) begin
                n_list[j] = r_list[j];
            end
        end
    end

    assign w_cnt_ext = {4'd0, r_cnt};
    assign w_knext   = {1'b0, r_k} + 1'b1;

    always_comb begin
        n_st   = r_st;
        n_idx  = r_idx;
        n_pend = 1'b0;
        n_cnt  = r_cnt;
        n_k    = r_k;
        n_ov   = r_ov && !i_pop;
        n_out  = r_out;
        o_take = 1'b0;
        case (r_st)
            ST_IDLE: begin
                if (i_valid) begin
                    case (i_cmd.kind)
                        CMD_READ: begin
                            if (i_cmd.oob) begin
                                if (w_emit_ok) begin
                                    o_take = 1'b1;
                                    n_ov   = 1'b1;
                                    n_out  = '0;
                                    n_out.status = 1'b1;
                                    n_out.last   = 1'b1;
                                end
                            end else begin
                                o_take = 1'b1;
                                n_st   = ST_READ;
                            end
                        end
                        CMD_SCAN: begin
                            o_take = 1'b1;
                            n_idx  = '0;
                            n_cnt  = '0;
                            n_st   = ST_SCAN;
                        end
                        default: begin
                            if (w_emit_ok) begin
                                o_take = 1'b1;
                                n_ov   = 1'b1;
                                n_out  = '0;
                                n_out.status = (i_cmd.kind == CMD_WRITE) && i_cmd.oob;
                                n_out.last   = 1'b1;
                            end
                        end
                    endcase
                end
            end
            ST_READ: begin
                if (w_emit_ok) begin
                    n_ov  = 1'b1;
                    n_out = '0;
                    n_out.read_data = w_byte[r_lane];
                    n_out.last      = 1'b1;
                    n_st  = ST_IDLE;
                end
            end
            ST_SCAN: begin
                n_pend = w_issue;
                if (w_issue) begin
                    n_idx = r_idx + 1'b1;
                end
                if (w_ins) begin
                    n_cnt = r_cnt + 1'b1;
                end
                if (!r_pend && !w_issue) begin
                    n_k  = '0;
                    n_st = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (w_emit_ok) begin
                    n_ov  = 1'b1;
                    n_out = '0;
                    n_out.sel_count = w_cnt_ext[3:0];
                    if (r_cnt == '0) begin
                        n_out.last = 1'b1;
                        n_st = ST_IDLE;
                    end else begin
                        n_out.sprite_y     = r_list[r_k].y;
                        n_out.sprite_x     = r_list[r_k].x;
                        n_out.sprite_tile  = r_list[r_k].tile;
                        n_out.sprite_flags = r_list[r_k].flags;
                        n_out.sprite_slot  = r_list[r_k].slot;
                        if (CW'(w_knext) == r_cnt) begin
                            n_out.last = 1'b1;
                            n_st = ST_IDLE;
                        end else begin
                            n_k = w_knext[KW-1:0];
                        end
                    end
                end
            end
            default: begin
                n_st = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st   <= ST_IDLE;
            r_vld  <= '0;
            r_idx  <= '0;
            r_pend <= 1'b0;
            r_cnt  <= '0;
            r_k    <= '0;
            r_ov   <= 1'b0;
        end else begin
            r_st   <= n_st;
            r_idx  <= n_idx;
            r_pend <= n_pend;
            r_cnt  <= n_cnt;
            r_k    <= n_k;
            r_ov   <= n_ov;
            for (int b = 0; b < 4; b++) begin
                if (w_we[b]) begin
                    r_vld[{i_cmd.entry[EW-1:0], 2'(b)}] <= 1'b1;
                end
            end
        end
        r_out  <= n_out;
        r_list <= n_list;
        if (r_st == ST_IDLE) begin
            r_lane   <= i_cmd.lane;
            r_rentry <= i_cmd.entry[EW-1:0];
            r_target <= i_cmd.target;
            r_height <= i_cmd.height;
            for (int b = 0; b < 4; b++) begin
                r_pvld[b] <= r_vld[{i_cmd.entry[EW-1:0], 2'(b)}];
            end
        end else if (w_issue) begin
            r_pslot <= 6'(r_idx);
            for (int b = 0; b < 4; b++) begin
                r_pvld[b] <= r_vld[{r_idx[EW-1:0], 2'(b)}];
            end
        end
    end

    assign o_empty  = !r_ov;
    assign o_result = r_out;
endmodule

// ----- design/sprite_attribute_line_scan_core.sv -----
// ----------------------------------------------------------------------------
// sprite_attribute_line_scan_core
// Sprite attribute memory with byte access and per-line sprite selection.
//
//   port group          direction  handshake
//   i_item / i_push     in         accepted on i_push && !o_full
//   o_result / i_pop    out        taken on i_pop && !o_empty
//
// A word is registered in the command queue. The back end answers writes and
// bad addresses from idle and reads via its read state. A scan is dispatched,
// walks one entry a cycle through the byte-lane RAMs, stopping once MAX_PER_LINE
// are kept, and emits one sprite a cycle while no result waits. A waiting result
// holds writes and results until i_pop; the two-deep queue keeps accepting
// meanwhile. Synchronous reset clears entries via per-byte valid bits.
// ----------------------------------------------------------------------------
module sprite_attribute_line_scan_core #(
    parameter int NUM_ENTRIES  = 40,
    parameter int MAX_PER_LINE = 10
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  salsc_pkg::t_in_word  i_item,
    output logic                 o_full,
    output logic                 o_empty,
    output salsc_pkg::t_out_word o_result,
    input  logic                 i_pop
);
    import salsc_pkg::*;

    logic      w_valid, w_take;
    t_cmd_word w_cmd;

    salsc_front #(.NUM_ENTRIES(NUM_ENTRIES)) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (i_push),
        .i_item  (i_item),
        .o_full  (o_full),
        .o_valid (w_valid),
        .o_cmd   (w_cmd),
        .i_take  (w_take)
    );

    salsc_back #(.NUM_ENTRIES(NUM_ENTRIES), .MAX_PER_LINE(MAX_PER_LINE)) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (w_valid),
        .i_cmd    (w_cmd),
        .o_take   (w_take),
        .o_empty  (o_empty),
        .o_result (o_result),
        .i_pop    (i_pop)
    );
endmodule

// ----- design/salsc_checker.sv -----
// ----------------------------------------------------------------------------
// salsc_checker
// Port-level checks for the sprite attribute line scan core.
// ----------------------------------------------------------------------------
module salsc_checker (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 o_empty,
    input salsc_pkg::t_out_word o_result,
    input logic                 i_pop
);
    import salsc_pkg::*;

    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> o_empty)
        else $error("result queue not empty after reset");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_empty && !i_pop) |=> (!o_empty && $stable(o_result)))
        else $error("waiting result changed");

    a_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_empty && !o_result.last) |-> (o_result.sel_count != 4'd0))
        else $error("non-final word outside a scan");

    a_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_empty && o_result.status) |->
        (o_result.last && o_result.sel_count == 4'd0 && o_result.read_data == 8'd0))
        else $error("bad out-of-bound word");

    a_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_empty && o_result.read_data != 8'd0) |->
        (o_result.last && o_result.sprite_x == 8'd0))
        else $error("read data on a scan word");
endmodule

bind sprite_attribute_line_scan_core salsc_checker u_salsc_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .o_empty  (o_empty),
    .o_result (o_result),
    .i_pop    (i_pop)
);
